### rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define PSD_ASSERT_IMPL(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
        else $error("implication check failed");

// next-cycle implication, disabled in reset
`define PSD_ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
        else $error("next-cycle check failed");

`endif

### rtl/psd_pkg.sv
// package for the point to segment distance unit: widths, types, codes
package psd_pkg;

    localparam int COORD_W  = 32;
    localparam int DIFF_W   = 33;
    localparam int PROD_W   = 66;
    localparam int DOT_W    = 67;
    localparam int DIV_STEPS = 16;
    localparam int T_W      = 17;
    localparam int TPROD_W  = 51;
    localparam int RES_W    = 35;
    localparam int RAD_W    = 70;
    localparam int ROOT_W   = 35;
    localparam int REM_W    = 38;
    localparam int DIST_W   = 33;
    localparam int IN_DATA_W  = 192;
    localparam int OUT_DATA_W = 40;

    localparam logic [T_W-1:0] T_FULL = T_W'(65536);

    typedef enum logic [1:0] {
        TSEL_ZERO,
        TSEL_ONE,
        TSEL_DIV
    } tsel_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] ox;
        logic signed [DIFF_W-1:0] oy;
        tsel_t                    tsel;
    } psd_side_t;

endpackage

### rtl/psd_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage
module psd_div_pipe (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 ce,
    input  logic                                 in_valid,
    input  logic [psd_pkg::PROD_W-1:0]           in_rem,
    input  logic [psd_pkg::PROD_W-1:0]           in_len2,
    input  psd_pkg::psd_side_t                   in_side,
    output logic                                 out_valid,
    output logic [psd_pkg::DIV_STEPS-1:0]        out_q,
    output psd_pkg::psd_side_t                   out_side
);
    import psd_pkg::*;

    logic                  valid_reg [DIV_STEPS];
    logic [PROD_W-1:0]     rem_reg   [DIV_STEPS];
    logic [PROD_W-1:0]     len2_reg  [DIV_STEPS];
    logic [DIV_STEPS-1:0]  q_reg     [DIV_STEPS];
    psd_side_t             side_reg  [DIV_STEPS];

    genvar j;
    generate
        for (j = 0; j < DIV_STEPS; j++) begin : g_step
            logic                 v_in;
            logic [PROD_W-1:0]    r_in;
            logic [PROD_W-1:0]    l_in;
            logic [DIV_STEPS-1:0] q_in;
            psd_side_t            s_in;
            logic [PROD_W:0]      shifted;
            logic                 take;
            logic [PROD_W-1:0]    rem_next;

            if (j == 0) begin : g_first
                assign v_in = in_valid;
                assign r_in = in_rem;
                assign l_in = in_len2;
                assign q_in = '0;
                assign s_in = in_side;
            end else begin : g_rest
                assign v_in = valid_reg[j-1];
                assign r_in = rem_reg[j-1];
                assign l_in = len2_reg[j-1];
                assign q_in = q_reg[j-1];
                assign s_in = side_reg[j-1];
            end

            assign shifted = {r_in, 1'b0};
            assign take = shifted >= {1'b0, l_in};
            assign rem_next = take ? PROD_W'(shifted - {1'b0, l_in}) : shifted[PROD_W-1:0];

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[j] <= 1'b0;
                end else if (ce) begin
                    valid_reg[j] <= v_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (ce) begin
                    rem_reg[j]  <= rem_next;
                    len2_reg[j] <= l_in;
                    q_reg[j]    <= {q_in[DIV_STEPS-2:0], take};
                    side_reg[j] <= s_in;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[DIV_STEPS-1];
    assign out_q     = q_reg[DIV_STEPS-1];
    assign out_side  = side_reg[DIV_STEPS-1];

endmodule

### rtl/psd_sqrt_pipe.sv
// pipelined digit-by-digit integer square root, one root bit per stage
module psd_sqrt_pipe (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          ce,
    input  logic                          in_valid,
    input  logic [psd_pkg::RAD_W-1:0]     in_rad,
    output logic                          out_valid,
    output logic [psd_pkg::ROOT_W-1:0]    out_root
);
    import psd_pkg::*;

    logic               valid_reg [ROOT_W];
    logic [RAD_W-1:0]   rad_reg   [ROOT_W];
    logic [REM_W-1:0]   rem_reg   [ROOT_W];
    logic [ROOT_W-1:0]  root_reg  [ROOT_W];

    genvar j;
    generate
        for (j = 0; j < ROOT_W; j++) begin : g_step
            logic              v_in;
            logic [RAD_W-1:0]  a_in;
            logic [REM_W-1:0]  r_in;
            logic [ROOT_W-1:0] q_in;
            logic [REM_W-1:0]  cand;
            logic [REM_W-1:0]  trial;
            logic              take;

            if (j == 0) begin : g_first
                assign v_in = in_valid;
                assign a_in = in_rad;
                assign r_in = '0;
                assign q_in = '0;
            end else begin : g_rest
                assign v_in = valid_reg[j-1];
                assign a_in = rad_reg[j-1];
                assign r_in = rem_reg[j-1];
                assign q_in = root_reg[j-1];
            end

            assign cand  = {r_in[REM_W-3:0], a_in[RAD_W-1 -: 2]};
            assign trial = REM_W'({q_in, 2'b01});
            assign take  = cand >= trial;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[j] <= 1'b0;
                end else if (ce) begin
                    valid_reg[j] <= v_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (ce) begin
                    rad_reg[j]  <= {a_in[RAD_W-3:0], 2'b00};
                    rem_reg[j]  <= take ? cand - trial : cand;
                    root_reg[j] <= {q_in[ROOT_W-2:0], take};
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];

endmodule

### rtl/point_to_segment_distance_unit.sv
// top level of the point to segment distance unit
//
//  channel | dir | tdata fields (lowest bit first)
//  s_      | in  | point_x, point_y, start_x, start_y, end_x, end_y (6 x 32, signed q16.16)
//  m_      | out | distance (33, unsigned q17.16), zero padded to 40
//
//  one transfer can enter in every cycle in which the pipeline advances; from input
//  to output register there are 4 setup stages, 16 divider stages, 4 nearest point
//  stages, 35 square root stages and the output register
//  the whole pipeline advances together whenever the output register is
//  empty or being taken, so a stall freezes every stage in place
//  reset clears only the valid bits
`include "assert_macros.svh"

module point_to_segment_distance_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // point_x, point_y, start_x, start_y, end_x, end_y
    input  logic [psd_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // distance, then zero padding
    output logic [psd_pkg::OUT_DATA_W-1:0]    m_tdata
);
    import psd_pkg::*;

    logic ce;
    assign ce = !m_tvalid || m_tready;
    assign s_tready = ce;

    // input unpack
    logic signed [COORD_W-1:0] px, py, sx, sy, ex, ey;
    assign px = s_tdata[31:0];
    assign py = s_tdata[63:32];
    assign sx = s_tdata[95:64];
    assign sy = s_tdata[127:96];
    assign ex = s_tdata[159:128];
    assign ey = s_tdata[191:160];

    // stage a: differences
    logic                     va_reg;
    logic signed [DIFF_W-1:0] dxa_reg, dya_reg, oxa_reg, oya_reg;

    // stage b: products
    logic                     vb_reg;
    logic signed [PROD_W-1:0] dxx_reg, dyy_reg, oxd_reg, oyd_reg;
    psd_side_t                sb_reg;

    // stage c: squared length and dot product
    logic                     vc_reg;
    logic [PROD_W-1:0]        len2_reg;
    logic signed [DOT_W-1:0]  dot_reg;
    psd_side_t                sc_reg;

    // stage d: projection classification
    logic                     vd_reg;
    logic [PROD_W-1:0]        rem_d_reg, len2_d_reg;
    psd_side_t                sd_reg;
    psd_side_t                sd_next;

    // divider output
    logic                     div_valid;
    logic [DIV_STEPS-1:0]     div_q;
    psd_side_t                div_side;

    // stage e: t times direction
    logic                      ve_reg;
    logic signed [TPROD_W-1:0] tdx_reg, tdy_reg;
    logic signed [DIFF_W-1:0]  oxe_reg, oye_reg;
    logic [T_W-1:0]            t_val;

    // stage f: residual offset
    logic                     vf_reg;
    logic signed [RES_W-1:0]  rx_reg, ry_reg;

    // stage g: squares, stage h: radicand
    logic                      vg_reg, vh_reg;
    logic signed [RAD_W-1:0]   rxx_reg, ryy_reg;
    logic [RAD_W-1:0]          rad_reg;

    // square root output
    logic                     sq_valid;
    logic [ROOT_W-1:0]        sq_root;

    logic                     out_valid_reg;
    logic [DIST_W-1:0]        dist_reg;

    always_comb begin
        sd_next = sc_reg;
        if (len2_reg == '0 || dot_reg <= 0) begin
            sd_next.tsel = TSEL_ZERO;
        end else if (dot_reg >= $signed({1'b0, len2_reg})) begin
            sd_next.tsel = TSEL_ONE;
        end else begin
            sd_next.tsel = TSEL_DIV;
        end
    end

    always_comb begin
        case (div_side.tsel)
            TSEL_ZERO: t_val = '0;
            TSEL_ONE:  t_val = T_FULL;
            TSEL_DIV:  t_val = T_W'(div_q);
            default:   t_val = '0;
        endcase
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            vd_reg        <= 1'b0;
            ve_reg        <= 1'b0;
            vf_reg        <= 1'b0;
            vg_reg        <= 1'b0;
            vh_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (ce) begin
            va_reg        <= s_tvalid;
            vb_reg        <= va_reg;
            vc_reg        <= vb_reg;
            vd_reg        <= vc_reg;
            ve_reg        <= div_valid;
            vf_reg        <= ve_reg;
            vg_reg        <= vf_reg;
            vh_reg        <= vg_reg;
            out_valid_reg <= sq_valid;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (ce) begin
            dxa_reg <= DIFF_W'($signed(ex) - $signed(sx));
            dya_reg <= DIFF_W'($signed(ey) - $signed(sy));
            oxa_reg <= DIFF_W'($signed(px) - $signed(sx));
            oya_reg <= DIFF_W'($signed(py) - $signed(sy));

            dxx_reg   <= dxa_reg * dxa_reg;
            dyy_reg   <= dya_reg * dya_reg;
            oxd_reg   <= oxa_reg * dxa_reg;
            oyd_reg   <= oya_reg * dya_reg;
            sb_reg.dx   <= dxa_reg;
            sb_reg.dy   <= dya_reg;
            sb_reg.ox   <= oxa_reg;
            sb_reg.oy   <= oya_reg;
            sb_reg.tsel <= TSEL_ZERO;

            len2_reg <= $unsigned(dxx_reg) + $unsigned(dyy_reg);
            dot_reg  <= DOT_W'(oxd_reg) + DOT_W'(oyd_reg);
            sc_reg   <= sb_reg;

            rem_d_reg  <= (sd_next.tsel == TSEL_DIV) ? dot_reg[PROD_W-1:0] : '0;
            len2_d_reg <= len2_reg;
            sd_reg     <= sd_next;

            // t is at most one, so the products stay within 51 bits
            tdx_reg <= $signed({1'b0, t_val}) * div_side.dx;
            tdy_reg <= $signed({1'b0, t_val}) * div_side.dy;
            oxe_reg <= div_side.ox;
            oye_reg <= div_side.oy;

            // arithmetic shift right by 16 is the floor toward minus infinity
            rx_reg <= RES_W'(oxe_reg) - tdx_reg[TPROD_W-1:16];
            ry_reg <= RES_W'(oye_reg) - tdy_reg[TPROD_W-1:16];

            rxx_reg <= rx_reg * rx_reg;
            ryy_reg <= ry_reg * ry_reg;

            rad_reg <= $unsigned(rxx_reg) + $unsigned(ryy_reg);

            dist_reg <= sq_root[DIST_W-1:0];
        end
    end

    psd_div_pipe u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (vd_reg),
        .in_rem    (rem_d_reg),
        .in_len2   (len2_d_reg),
        .in_side   (sd_reg),
        .out_valid (div_valid),
        .out_q     (div_q),
        .out_side  (div_side)
    );

    psd_sqrt_pipe u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (vh_reg),
        .in_rad    (rad_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(dist_reg);

    // a remainder handed to the divider is always below the squared length
    `PSD_ASSERT_IMPL(a_div_rem_below_len, aclk, aresetn, vd_reg && (sd_reg.tsel == TSEL_DIV), rem_d_reg < len2_d_reg)
    // a finished root reaches the output register on an advancing edge
    `PSD_ASSERT_NEXT(a_root_to_out, aclk, aresetn, ce && sq_valid, m_tvalid)
    // a frozen pipeline keeps its first stage
    `PSD_ASSERT_NEXT(a_stall_holds_a, aclk, aresetn, !ce, $stable(va_reg))

endmodule

### sim/point_to_segment_distance_unit_tb.sv
// testbench for the point to segment distance unit: random and directed transfers, scoreboard check
module point_to_segment_distance_unit_tb;
    import psd_pkg::*;

    localparam int PIPE_LAT = 60;

    // reference distance calculation, exact wide arithmetic
    function automatic logic [DIST_W-1:0] seg_distance(logic signed [31:0] px, logic signed [31:0] py,
                                                       logic signed [31:0] sx, logic signed [31:0] sy,
                                                       logic signed [31:0] ex, logic signed [31:0] ey);
        logic signed [127:0] dx, dy, ox, oy, len2, dot, tq, rx, ry, rad, offx, offy;
        logic [127:0] root, cand;
        dx = $signed(ex) - $signed(sx);
        dy = $signed(ey) - $signed(sy);
        ox = $signed(px) - $signed(sx);
        oy = $signed(py) - $signed(sy);
        len2 = dx * dx + dy * dy;
        tq = 0;
        if (len2 != 0) begin
            dot = ox * dx + oy * dy;
            if (dot <= 0) tq = 0;
            else if (dot >= len2) tq = 65536;
            else tq = (dot <<< 16) / len2;
        end
        // arithmetic shift floors toward minus infinity
        offx = (tq * dx) >>> 16;
        offy = (tq * dy) >>> 16;
        rx = ox - offx;
        ry = oy - offy;
        rad = rx * rx + ry * ry;
        root = 0;
        for (int b = 33; b >= 0; b--) begin
            cand = root | (128'd1 << b);
            if (cand * cand <= rad) root = cand;
        end
        return root[DIST_W-1:0];
    endfunction

    class distance_scoreboard;
        logic [DIST_W-1:0] pending_dist[$];
        int mismatches = 0;

        function void note_input(logic [IN_DATA_W-1:0] d);
            pending_dist.push_back(seg_distance(d[31:0], d[63:32], d[95:64], d[127:96],
                                                d[159:128], d[191:160]));
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] d);
            logic [DIST_W-1:0] want;
            if (pending_dist.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result distance=%h", d[DIST_W-1:0]);
                return;
            end
            want = pending_dist.pop_front();
            if (d[DIST_W-1:0] !== want || d[OUT_DATA_W-1:DIST_W] !== '0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("distance mismatch: expected %h got %h", want, d);
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [OUT_DATA_W-1:0] m_tdata;

    distance_scoreboard board = new();
    bit sink_hold = 0;
    bit stim_done = 0;

    always #5 aclk = ~aclk;

    point_to_segment_distance_unit uut (.*);

    // score every transfer on both channels
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) board.note_input(s_tdata);
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);
    end

    // coordinate with random magnitude so both tiny and huge segments appear
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed(16'($urandom())));
            2: return 32'h8000_0000 + $urandom_range(0, 3);
            3: return 32'h7fff_ffff - $urandom_range(0, 3);
            default: return 32'($signed(24'($urandom())));
        endcase
    endfunction

    // valid stays up after a transfer so back to back items need no second drive
    task automatic send(logic [IN_DATA_W-1:0] d, int gap);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= d;
        s_tvalid <= 1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_pts(logic [31:0] px, py, sx, sy, ex, ey);
        send({ey, ex, sy, sx, py, px}, 0);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        wait (board.pending_dist.size() == 0);
        @(posedge aclk);
    endtask

    logic [31:0] mx = 32'h7fff_ffff, mn = 32'h8000_0000;

    // source side
    initial begin
        logic [31:0] c[6];
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: zero length, ends, interior, extremes
        send_pts(0, 0, 0, 0, 0, 0);
        send_pts(32'h0001_0000, 32'h0002_0000, 5, 5, 5, 5);
        send_pts(mx, mx, mn, mn, mn, mn);
        send_pts(mn, mn, mx, mx, mx, mx);
        send_pts(mn, 0, 0, 0, 32'h0001_0000, 0);
        send_pts(mx, 0, 0, 0, 32'h0001_0000, 0);
        send_pts(32'h0000_8000, 32'h0001_0000, 0, 0, 32'h0001_0000, 0);
        send_pts(1, 7, 0, 0, 3, 0);
        send_pts(mx, mn, mn, mx, mx, mn);
        send_pts(0, 0, mn, mn, mx, mx);
        send_pts(mx, mn, mn, mn, mx, mx);
        send_pts(32'hffff_ffff, 32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa, mn, mx);
        send_pts(3, 1, 0, 0, 7, 3);
        send_pts(32'h0000_0001, 32'hffff_ffff, 0, 0, 1, 0);
        drain();
        // long pause until every result is back
        for (int i = 0; i < 1000; i++) begin
            foreach (c[k]) c[k] = rand_coord();
            if ($urandom_range(0, 9) == 0) begin
                c[4] = c[2];
                c[5] = c[3];
            end
            if (i == 500) drain();
            send({c[5], c[4], c[3], c[2], c[1], c[0]},
                 ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11));
        end
        s_tvalid <= 0;
        stim_done = 1;
    end

    // sink side with random stalls and one long hold-off
    initial begin
        int hold;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (sink_hold) begin
                m_tready <= 0;
            end else if (m_tready && !m_tvalid) begin
                // keep ready while waiting
            end else if (m_tready && m_tvalid) begin
                hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
                if (hold != 0) begin
                    m_tready <= 0;
                    repeat (hold) @(posedge aclk);
                    m_tready <= 1;
                end
            end else begin
                m_tready <= 1;
            end
        end
    end

    // long receiver stall while the sender keeps offering
    initial begin
        repeat (400) @(posedge aclk);
        sink_hold = 1;
        repeat (300) @(posedge aclk);
        sink_hold = 0;
    end

    initial begin
        wait (stim_done);
        wait (board.pending_dist.size() == 0);
        repeat (PIPE_LAT + 20) @(posedge aclk);
        if (board.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
